[rtl/hrt_pkg.sv]
package hrt_pkg;

    // Default sizes
    localparam int DEF_MAX_RULES       = 1024;
    localparam int DEF_MAX_KEY_BYTES   = 256;
    localparam int DEF_KEY_STORE_BYTES = 65536;
    localparam int DEF_BUCKETS         = 2048;

    // FNV-1a 64
    localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;

    // Rule field limits
    localparam int          MEMBER_SLOTS = 33;
    localparam int          FAMILY_COUNT = 128;
    localparam int          PAIR_SLOTS   = FAMILY_COUNT * MEMBER_SLOTS;
    localparam logic [5:0]  MEMBER_MAX   = 6'd32;
    localparam logic [7:0]  TGC_LIMIT    = 8'd128;
    localparam logic [15:0] NO_TARGET    = 16'hFFFF;
    localparam int          RULE_INDEX_W = 10;

    typedef enum logic [1:0] {
        KIND_LOAD   = 2'd0,
        KIND_LOOKUP = 2'd1,
        KIND_CLEAR  = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_MISS    = 3'd1,
        ST_INVALID = 3'd2,
        ST_DUP     = 3'd3,
        ST_FAILED  = 3'd4
    } status_t;

    typedef struct packed {
        logic        action;
        logic [15:0] target;
        logic [6:0]  family;
        logic [5:0]  member;
    } attr_t;

    typedef struct packed {
        logic        bound;
        logic        action;
        logic [15:0] target;
    } fam_bind_t;

    // Commands from the sequencer to the key accumulator
    typedef struct packed {
        logic push;
        logic restart;
    } key_cmd_t;

    // One FNV-1a step; the prime is 2^40 + 0x1B3
    function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] x;
        x = h ^ {56'd0, b};
        return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    endfunction

endpackage

[rtl/hashed_rule_table_load_and_lookup.sv]
// Hashed rule table. Keys arrive one byte per request (kind 0 load, 1 lookup) and are
// folded into an FNV-1a 64 hash; a byte without key_last leaves the block idle. The byte
// with key_last starts the rule work and holds busy until the result appears on done for a
// single cycle; the receiver cannot stall, so take every result when done is high.
// Per finished key the bucket is found, by a serial bucket remainder when BUCKETS is not a
// power of two. A load that passes its checks runs the ascending-order compare against the
// previous key, the copy into the key store and a commit. A lookup walks the bucket chain
// and byte-compares each entry whose hash and length match. These loops are bound by the
// single read port of the key store and key buffer memories. After reset and after every
// clear request the block runs a clearing pass over the bucket, pair and family memories
// with busy high. Failed loads latch a table failure (status 4) until a clear request.
module hashed_rule_table_load_and_lookup
    import hrt_pkg::*;
#(
    parameter int MAX_RULES       = DEF_MAX_RULES,
    parameter int MAX_KEY_BYTES   = DEF_MAX_KEY_BYTES,
    parameter int KEY_STORE_BYTES = DEF_KEY_STORE_BYTES,
    parameter int BUCKETS         = DEF_BUCKETS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  kind,
    input  logic [7:0]  key_byte,
    input  logic        key_last,
    input  logic        action,
    input  logic [15:0] target_group,
    input  logic [6:0]  family,
    input  logic [5:0]  member,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    output logic        done,
    output logic [2:0]  status,
    output logic [9:0]  rule_index,
    output logic        found_action,
    output logic [15:0] found_target,
    output logic [6:0]  found_family,
    output logic [5:0]  found_member
);

    localparam int IDX_W     = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam int LINK_W    = $clog2(MAX_RULES + 1);
    localparam int LEN_W     = $clog2(MAX_KEY_BYTES + 2);
    localparam int KB_AW     = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam int SA_W      = $clog2(KEY_STORE_BYTES);
    localparam int CUR_W     = $clog2(KEY_STORE_BYTES + 1);
    localparam int SUM_W     = ((CUR_W > LEN_W) ? CUR_W : LEN_W) + 1;
    localparam int BK_AW     = $clog2(BUCKETS);
    localparam bit BK_POW2   = ((BUCKETS & (BUCKETS - 1)) == 0);
    localparam int PAIR_AW   = $clog2(PAIR_SLOTS);
    localparam int FAM_AW    = $clog2(FAMILY_COUNT);
    localparam int SWEEP_LEN = (BUCKETS > PAIR_SLOTS) ? BUCKETS : PAIR_SLOTS;
    localparam int SW_W      = $clog2(SWEEP_LEN);
    localparam int ATTR_W    = $bits(attr_t);
    localparam int FB_W      = $bits(fam_bind_t);
    localparam int RULE_W    = 64 + SA_W + LEN_W + ATTR_W + LINK_W;

    localparam logic [SW_W:0] BK_LIM   = (SW_W + 1)'(BUCKETS);
    localparam logic [SW_W:0] PAIR_LIM = (SW_W + 1)'(PAIR_SLOTS);
    localparam logic [SW_W:0] FAM_LIM  = (SW_W + 1)'(FAMILY_COUNT);

    typedef enum logic [11:0] {
        S_IDLE    = 12'b000000000001,
        S_SWEEP   = 12'b000000000010,
        S_HMOD    = 12'b000000000100,
        S_DISP    = 12'b000000001000,
        S_LCHK    = 12'b000000010000,
        S_LORD    = 12'b000000100000,
        S_LCOPY   = 12'b000001000000,
        S_LCOMMIT = 12'b000010000000,
        S_QHEAD   = 12'b000100000000,
        S_QWALK   = 12'b001000000000,
        S_QRULE   = 12'b010000000000,
        S_QCMP    = 12'b100000000000
    } state_t;

    // Control registers
    state_t            state_reg, state_next;
    logic [SW_W-1:0]   sweep_cnt_reg, sweep_cnt_next;
    logic              load_failed_reg, load_failed_next;
    logic [LINK_W-1:0] rule_count_reg, rule_count_next;
    logic [CUR_W-1:0]  cursor_reg, cursor_next;
    logic [7:0]        tgc_reg, tgc_next;
    logic              done_reg, done_next;
    logic              cmp_pend_reg, cmp_pend_next;
    logic              cp_pend_reg, cp_pend_next;

    // Working registers
    logic [SA_W-1:0]    last_off_reg, last_off_next;
    logic [LEN_W-1:0]   last_len_reg, last_len_next;
    kind_t              kind_reg, kind_next;
    attr_t              cap_attr_reg, cap_attr_next;
    logic [PAIR_AW-1:0] pair_addr_reg, pair_addr_next;
    logic [BK_AW-1:0]   bucket_reg, bucket_next;
    logic [BK_AW-1:0]   mod_rem_reg, mod_rem_next;
    logic [5:0]         mod_cnt_reg, mod_cnt_next;
    logic [LINK_W-1:0]  idx_reg, idx_next;
    logic [LINK_W-1:0]  steps_reg, steps_next;
    logic [SA_W-1:0]    cmp_base_reg, cmp_base_next;
    logic [LEN_W-1:0]   cmp_len_reg, cmp_len_next;
    logic [LEN_W-1:0]   cmp_i_reg, cmp_i_next;
    logic [LEN_W-1:0]   cp_i_reg, cp_i_next;
    logic [LEN_W-1:0]   cp_w_reg, cp_w_next;
    status_t            status_reg, status_next;
    logic [RULE_INDEX_W-1:0] rule_index_reg, rule_index_next;
    attr_t              attr_out_reg, attr_out_next;

    // Key accumulator
    key_cmd_t          key_cmd;
    logic [KB_AW-1:0]  kb_raddr;
    logic [7:0]        kb_rd;
    logic [LEN_W-1:0]  key_len;
    logic [63:0]       key_hash;

    // Memory ports
    logic              sweep_on, commit_on;
    logic [SW_W:0]     sweep_ext;
    logic              ks_we;
    logic [SA_W-1:0]   ks_waddr, ks_raddr;
    logic [7:0]        ks_rd;
    logic              bk_we;
    logic [BK_AW-1:0]  bk_waddr;
    logic [LINK_W-1:0] bk_wdata, bk_rd;
    logic              ps_we;
    logic [PAIR_AW-1:0] ps_waddr;
    logic              ps_wdata, ps_rd;
    logic              fb_we;
    logic [FAM_AW-1:0] fb_waddr;
    fam_bind_t         fb_wdata, fb_rd;
    logic [RULE_W-1:0] rule_wdata, rule_rd;

    // Rule entry fields
    logic [63:0]       rr_hash;
    logic [SA_W-1:0]   rr_off;
    logic [LEN_W-1:0]  rr_len;
    attr_t             rr_attr;
    logic [LINK_W-1:0] rr_next;

    // Datapath conditions
    logic              len_big, store_over, load_bad;
    logic [BK_AW:0]    mod_t;
    logic [BK_AW-1:0]  mod_red;
    logic              cmp_diff, cmp_less, cmp_end, cmp_more, cp_more;
    logic [LEN_W-1:0]  ord_len;

    // Result of the current key
    logic              fin_valid;
    status_t           fin_status;
    logic [LINK_W-1:0] fin_idx;
    attr_t             fin_attr;

    assign busy = (state_reg != S_IDLE);

    assign {rr_hash, rr_off, rr_len, rr_attr, rr_next} = rule_rd;

    // Load field checks
    assign len_big    = key_len > LEN_W'(MAX_KEY_BYTES);
    assign store_over = (SUM_W'(cursor_reg) + SUM_W'(key_len)) > SUM_W'(KEY_STORE_BYTES);
    assign load_bad   = (cap_attr_reg.member > MEMBER_MAX) || len_big ||
                        (tgc_reg > TGC_LIMIT) || (rule_count_reg >= LINK_W'(MAX_RULES)) ||
                        store_over ||
                        (!cap_attr_reg.action && (cap_attr_reg.target >= {8'd0, tgc_reg})) ||
                        (cap_attr_reg.action && (cap_attr_reg.target != NO_TARGET));

    // Serial bucket remainder, one hash bit per cycle from the top
    assign mod_t   = {mod_rem_reg, key_hash[~mod_cnt_reg]};
    assign mod_red = (mod_t >= (BK_AW + 1)'(BUCKETS)) ?
                     BK_AW'(mod_t - (BK_AW + 1)'(BUCKETS)) : mod_t[BK_AW-1:0];

    // Byte compare engine: issue one address per cycle, compare the read data in the next cycle
    assign cmp_diff = cmp_pend_reg && (ks_rd != kb_rd);
    assign cmp_less = ks_rd < kb_rd;
    assign cmp_more = cmp_i_reg < cmp_len_reg;
    assign cmp_end  = !cmp_pend_reg && !cmp_more;
    assign ord_len  = (last_len_reg < key_len) ? last_len_reg : key_len;
    assign cp_more  = cp_i_reg < key_len;

    always_comb
    begin
        state_next       = state_reg;
        sweep_cnt_next   = sweep_cnt_reg;
        load_failed_next = load_failed_reg;
        rule_count_next  = rule_count_reg;
        cursor_next      = cursor_reg;
        tgc_next         = tgc_reg;
        done_next        = 1'b0;
        cmp_pend_next    = cmp_pend_reg;
        cp_pend_next     = cp_pend_reg;
        last_off_next    = last_off_reg;
        last_len_next    = last_len_reg;
        kind_next        = kind_reg;
        cap_attr_next    = cap_attr_reg;
        pair_addr_next   = pair_addr_reg;
        bucket_next      = bucket_reg;
        mod_rem_next     = mod_rem_reg;
        mod_cnt_next     = mod_cnt_reg;
        idx_next         = idx_reg;
        steps_next       = steps_reg;
        cmp_base_next    = cmp_base_reg;
        cmp_len_next     = cmp_len_reg;
        cmp_i_next       = cmp_i_reg;
        cp_i_next        = cp_i_reg;
        cp_w_next        = cp_w_reg;
        status_next      = status_reg;
        rule_index_next  = rule_index_reg;
        attr_out_next    = attr_out_reg;
        key_cmd          = '0;
        fin_valid        = 1'b0;
        fin_status       = ST_OK;
        fin_idx          = '0;
        fin_attr         = '0;

        if (cfg_we)
        begin
            tgc_next = cfg_wdata;
        end

        // Compare engine advance
        if ((state_reg == S_LORD) || (state_reg == S_QCMP))
        begin
            cmp_pend_next = cmp_more && !cmp_diff;
            if (cmp_more && !cmp_diff)
            begin
                cmp_i_next = cmp_i_reg + 1'b1;
            end
        end

        // Copy engine advance: read key buffer, write key store in the next cycle
        if (state_reg == S_LCOPY)
        begin
            cp_pend_next = cp_more;
            if (cp_more)
            begin
                cp_w_next = cp_i_reg;
                cp_i_next = cp_i_reg + 1'b1;
            end
        end

        case (state_reg)
            S_SWEEP:
            begin
                if (sweep_cnt_reg == SW_W'(SWEEP_LEN - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    sweep_cnt_next = sweep_cnt_reg + 1'b1;
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    kind_next      = kind_t'(kind);
                    cap_attr_next  = '{action: action, target: target_group,
                                       family: family, member: member};
                    pair_addr_next = PAIR_AW'({family, 5'd0}) + PAIR_AW'(family) +
                                     PAIR_AW'(member);
                    case (kind_t'(kind))
                        KIND_CLEAR:
                        begin
                            state_next       = S_SWEEP;
                            sweep_cnt_next   = '0;
                            rule_count_next  = '0;
                            cursor_next      = '0;
                            load_failed_next = 1'b0;
                            key_cmd.restart  = 1'b1;
                        end
                        KIND_LOAD, KIND_LOOKUP:
                        begin
                            key_cmd.push = 1'b1;
                            if (key_last)
                            begin
                                state_next   = S_HMOD;
                                mod_cnt_next = '0;
                                mod_rem_next = '0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_HMOD:
            begin
                if (BK_POW2)
                begin
                    bucket_next = key_hash[BK_AW-1:0];
                    state_next  = S_DISP;
                end
                else
                begin
                    mod_rem_next = mod_red;
                    mod_cnt_next = mod_cnt_reg + 1'b1;
                    if (mod_cnt_reg == 6'd63)
                    begin
                        bucket_next = mod_red;
                        state_next  = S_DISP;
                    end
                end
            end

            S_DISP:
            begin
                if (load_failed_reg)
                begin
                    fin_valid  = 1'b1;
                    fin_status = ST_FAILED;
                end
                else if (kind_reg == KIND_LOOKUP)
                begin
                    if (len_big)
                    begin
                        fin_valid  = 1'b1;
                        fin_status = ST_MISS;
                    end
                    else
                    begin
                        state_next = S_QHEAD;
                    end
                end
                else if (load_bad)
                begin
                    fin_valid  = 1'b1;
                    fin_status = ST_INVALID;
                end
                else
                begin
                    state_next = S_LCHK;
                end
            end

            // Pair and family binding reads are back
            S_LCHK:
            begin
                if (ps_rd)
                begin
                    fin_valid  = 1'b1;
                    fin_status = ST_DUP;
                end
                else if (fb_rd.bound && ((fb_rd.action != cap_attr_reg.action) ||
                                         (fb_rd.target != cap_attr_reg.target)))
                begin
                    fin_valid  = 1'b1;
                    fin_status = ST_INVALID;
                end
                else if (rule_count_reg != '0)
                begin
                    state_next    = S_LORD;
                    cmp_base_next = last_off_reg;
                    cmp_len_next  = ord_len;
                    cmp_i_next    = '0;
                    cmp_pend_next = 1'b0;
                end
                else
                begin
                    state_next   = S_LCOPY;
                    cp_i_next    = '0;
                    cp_pend_next = 1'b0;
                end
            end

            // New key must sort strictly above the previous one
            S_LORD:
            begin
                if (cmp_diff || cmp_end)
                begin
                    if (cmp_diff ? cmp_less : (last_len_reg < key_len))
                    begin
                        state_next   = S_LCOPY;
                        cp_i_next    = '0;
                        cp_pend_next = 1'b0;
                    end
                    else
                    begin
                        fin_valid  = 1'b1;
                        fin_status = ST_DUP;
                    end
                end
            end

            S_LCOPY:
            begin
                if (!cp_pend_reg && !cp_more)
                begin
                    state_next = S_LCOMMIT;
                end
            end

            // Rule entry, bucket head, pair and binding written this cycle
            S_LCOMMIT:
            begin
                rule_count_next = rule_count_reg + 1'b1;
                cursor_next     = cursor_reg + CUR_W'(key_len);
                last_off_next   = cursor_reg[SA_W-1:0];
                last_len_next   = key_len;
                fin_valid       = 1'b1;
                fin_status      = ST_OK;
                fin_idx         = rule_count_reg;
                fin_attr        = cap_attr_reg;
            end

            S_QHEAD:
            begin
                idx_next   = bk_rd;
                steps_next = '0;
                state_next = S_QWALK;
            end

            // Empty link is all ones and so never below the rule count
            S_QWALK:
            begin
                if ((idx_reg >= rule_count_reg) || (steps_reg >= rule_count_reg))
                begin
                    fin_valid  = 1'b1;
                    fin_status = ST_MISS;
                end
                else
                begin
                    state_next = S_QRULE;
                end
            end

            S_QRULE:
            begin
                if ((rr_hash == key_hash) && (rr_len == key_len))
                begin
                    state_next    = S_QCMP;
                    cmp_base_next = rr_off;
                    cmp_len_next  = key_len;
                    cmp_i_next    = '0;
                    cmp_pend_next = 1'b0;
                end
                else
                begin
                    idx_next   = rr_next;
                    steps_next = steps_reg + 1'b1;
                    state_next = S_QWALK;
                end
            end

            S_QCMP:
            begin
                if (cmp_diff)
                begin
                    idx_next   = rr_next;
                    steps_next = steps_reg + 1'b1;
                    state_next = S_QWALK;
                end
                else if (cmp_end)
                begin
                    fin_valid  = 1'b1;
                    fin_status = ST_OK;
                    fin_idx    = idx_reg;
                    fin_attr   = rr_attr;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Present the result and drop the finished key
        if (fin_valid)
        begin
            state_next      = S_IDLE;
            key_cmd.restart = 1'b1;
            done_next       = 1'b1;
            status_next     = fin_status;
            if (fin_status == ST_OK)
            begin
                rule_index_next = RULE_INDEX_W'(fin_idx);
                attr_out_next   = fin_attr;
            end
            else
            begin
                rule_index_next = '0;
                attr_out_next   = '0;
            end
            if ((kind_reg == KIND_LOAD) && (fin_status != ST_OK))
            begin
                load_failed_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_SWEEP;
            sweep_cnt_reg   <= '0;
            load_failed_reg <= 1'b0;
            rule_count_reg  <= '0;
            cursor_reg      <= '0;
            tgc_reg         <= '0;
            done_reg        <= 1'b0;
            cmp_pend_reg    <= 1'b0;
            cp_pend_reg     <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            sweep_cnt_reg   <= sweep_cnt_next;
            load_failed_reg <= load_failed_next;
            rule_count_reg  <= rule_count_next;
            cursor_reg      <= cursor_next;
            tgc_reg         <= tgc_next;
            done_reg        <= done_next;
            cmp_pend_reg    <= cmp_pend_next;
            cp_pend_reg     <= cp_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_off_reg   <= last_off_next;
        last_len_reg   <= last_len_next;
        kind_reg       <= kind_next;
        cap_attr_reg   <= cap_attr_next;
        pair_addr_reg  <= pair_addr_next;
        bucket_reg     <= bucket_next;
        mod_rem_reg    <= mod_rem_next;
        mod_cnt_reg    <= mod_cnt_next;
        idx_reg        <= idx_next;
        steps_reg      <= steps_next;
        cmp_base_reg   <= cmp_base_next;
        cmp_len_reg    <= cmp_len_next;
        cmp_i_reg      <= cmp_i_next;
        cp_i_reg       <= cp_i_next;
        cp_w_reg       <= cp_w_next;
        status_reg     <= status_next;
        rule_index_reg <= rule_index_next;
        attr_out_reg   <= attr_out_next;
    end

    // Memory port muxing
    assign sweep_on  = (state_reg == S_SWEEP);
    assign commit_on = (state_reg == S_LCOMMIT);
    assign sweep_ext = {1'b0, sweep_cnt_reg};

    assign kb_raddr = (state_reg == S_LCOPY) ? cp_i_reg[KB_AW-1:0] : cmp_i_reg[KB_AW-1:0];

    assign ks_we    = (state_reg == S_LCOPY) && cp_pend_reg;
    assign ks_waddr = cursor_reg[SA_W-1:0] + SA_W'(cp_w_reg);
    assign ks_raddr = cmp_base_reg + SA_W'(cmp_i_reg);

    assign bk_we    = (sweep_on && (sweep_ext < BK_LIM)) || commit_on;
    assign bk_waddr = sweep_on ? sweep_cnt_reg[BK_AW-1:0] : bucket_reg;
    assign bk_wdata = sweep_on ? '1 : rule_count_reg;

    assign ps_we    = (sweep_on && (sweep_ext < PAIR_LIM)) || commit_on;
    assign ps_waddr = sweep_on ? sweep_cnt_reg[PAIR_AW-1:0] : pair_addr_reg;
    assign ps_wdata = !sweep_on;

    assign fb_we    = (sweep_on && (sweep_ext < FAM_LIM)) || commit_on;
    assign fb_waddr = sweep_on ? sweep_cnt_reg[FAM_AW-1:0] : cap_attr_reg.family;
    assign fb_wdata = sweep_on ? '0 : '{bound: 1'b1, action: cap_attr_reg.action,
                                       target: cap_attr_reg.target};

    assign rule_wdata = {key_hash, cursor_reg[SA_W-1:0], key_len, cap_attr_reg, bk_rd};

    hrt_key_acc #(.MAX_KEY_BYTES(MAX_KEY_BYTES)) u_key_acc (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (key_cmd),
        .key_byte (key_byte),
        .rd_addr  (kb_raddr),
        .rd_data  (kb_rd),
        .key_len  (key_len),
        .key_hash (key_hash)
    );

    // Key store
    hrt_ram #(.WIDTH(8), .DEPTH(KEY_STORE_BYTES)) u_key_store (
        .clk   (clk),
        .we    (ks_we),
        .waddr (ks_waddr),
        .wdata (kb_rd),
        .raddr (ks_raddr),
        .rdata (ks_rd)
    );

    // Bucket heads
    hrt_ram #(.WIDTH(LINK_W), .DEPTH(BUCKETS)) u_bucket (
        .clk   (clk),
        .we    (bk_we),
        .waddr (bk_waddr),
        .wdata (bk_wdata),
        .raddr (bucket_reg),
        .rdata (bk_rd)
    );

    // Rule entries: hash, key offset and length, attributes, chain link
    hrt_ram #(.WIDTH(RULE_W), .DEPTH(MAX_RULES)) u_rule (
        .clk   (clk),
        .we    (commit_on),
        .waddr (rule_count_reg[IDX_W-1:0]),
        .wdata (rule_wdata),
        .raddr (idx_reg[IDX_W-1:0]),
        .rdata (rule_rd)
    );

    // Family/member pairs already loaded
    hrt_ram #(.WIDTH(1), .DEPTH(PAIR_SLOTS)) u_pair (
        .clk   (clk),
        .we    (ps_we),
        .waddr (ps_waddr),
        .wdata (ps_wdata),
        .raddr (pair_addr_reg),
        .rdata (ps_rd)
    );

    // Family action/target bindings
    hrt_ram #(.WIDTH(FB_W), .DEPTH(FAMILY_COUNT)) u_family (
        .clk   (clk),
        .we    (fb_we),
        .waddr (fb_waddr),
        .wdata (fb_wdata),
        .raddr (cap_attr_reg.family),
        .rdata (fb_rd)
    );

    assign done         = done_reg;
    assign status       = status_reg;
    assign rule_index   = rule_index_reg;
    assign found_action = attr_out_reg.action;
    assign found_target = attr_out_reg.target;
    assign found_family = attr_out_reg.family;
    assign found_member = attr_out_reg.member;

    // Results only come out once the sequencer is back in idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_rule_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rule_count_reg <= LINK_W'(MAX_RULES))
        else $error("rule count beyond capacity");

    a_store_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_reg <= CUR_W'(KEY_STORE_BYTES))
        else $error("key store cursor beyond capacity");

    // A latched failure answers every finished load or lookup key with the failed status
    a_failed: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && $past(load_failed_reg) |-> status_reg == ST_FAILED)
        else $error("request served on a failed table");

    a_load_count: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && (status_reg == ST_OK) && (kind_reg == KIND_LOAD) |->
        rule_count_reg == LINK_W'($past(rule_count_reg) + 1'b1))
        else $error("successful load did not add a rule");

endmodule

[rtl/hrt_ram.sv]
module hrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/hrt_key_acc.sv]
module hrt_key_acc
    import hrt_pkg::*;
#(
    parameter int MAX_KEY_BYTES = DEF_MAX_KEY_BYTES,
    localparam int LEN_W = $clog2(MAX_KEY_BYTES + 2),
    localparam int KB_AW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  key_cmd_t         cmd,
    input  logic [7:0]       key_byte,
    input  logic [KB_AW-1:0] rd_addr,
    output logic [7:0]       rd_data,
    output logic [LEN_W-1:0] key_len,
    output logic [63:0]      key_hash
);

    logic [LEN_W-1:0] len_reg, len_next;
    logic [63:0]      hash_reg, hash_next;
    logic             buf_we;

    // Bytes past the buffer are dropped; length saturates one above the limit
    assign buf_we = cmd.push && (len_reg < LEN_W'(MAX_KEY_BYTES));

    always_comb
    begin
        len_next  = len_reg;
        hash_next = hash_reg;
        if (cmd.restart)
        begin
            len_next  = '0;
            hash_next = FNV_BASIS;
        end
        else if (cmd.push)
        begin
            if (len_reg <= LEN_W'(MAX_KEY_BYTES))
            begin
                len_next = len_reg + 1'b1;
            end
            hash_next = fnv_step(hash_reg, key_byte);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= '0;
            hash_reg <= FNV_BASIS;
        end
        else
        begin
            len_reg  <= len_next;
            hash_reg <= hash_next;
        end
    end

    // Key buffer
    hrt_ram #(.WIDTH(8), .DEPTH(MAX_KEY_BYTES)) u_key_buf (
        .clk   (clk),
        .we    (buf_we),
        .waddr (len_reg[KB_AW-1:0]),
        .wdata (key_byte),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    assign key_len  = len_reg;
    assign key_hash = hash_reg;

endmodule

[sim/hashed_rule_table_load_and_lookup_tb.sv]
`timescale 1ns / 100ps

module hashed_rule_table_load_and_lookup_tb;
    import hrt_pkg::*;

    localparam int  N_RULES    = 1024;
    localparam int  N_KEYB     = 256;
    localparam int  N_STORE    = 65536;
    localparam int  N_BUCKETS  = 2048;
    localparam longint LIMIT   = 3000000;
    localparam logic [63:0] PRIME = 64'd1099511628211;

    typedef struct {
        kind_t       kind;
        logic [7:0]  b;
        logic        last;
        logic        act;
        logic [15:0] tgt;
        logic [6:0]  fam;
        logic [5:0]  mem;
    } req_t;

    typedef struct {
        status_t     st;
        logic [9:0]  idx;
        attr_t       a;
    } rule_res_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  kind;
    logic [7:0]  key_byte;
    logic        key_last;
    logic        action;
    logic [15:0] target_group;
    logic [6:0]  family;
    logic [5:0]  member;
    logic        cfg_we;
    logic [7:0]  cfg_wdata;
    logic        done;
    logic [2:0]  status;
    logic [9:0]  rule_index;
    logic        found_action;
    logic [15:0] found_target;
    logic [6:0]  found_family;
    logic [5:0]  found_member;

    hashed_rule_table_load_and_lookup dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .kind(kind), .key_byte(key_byte), .key_last(key_last), .action(action),
        .target_group(target_group), .family(family), .member(member),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .done(done), .status(status),
        .rule_index(rule_index), .found_action(found_action),
        .found_target(found_target), .found_family(found_family),
        .found_member(found_member)
    );

    // Clock: 12 ns period
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    req_t      pending_reqs[$];
    rule_res_t expected_rules[$];
    req_t      cur;
    int        gap_left;
    bit        no_idle;
    int        errors;
    longint    cycles;

    // ---------------- table predictor ----------------
    logic [7:0]  t_kbuf[N_KEYB];
    int          t_klen;
    logic [63:0] t_hash;
    logic [63:0] t_rhash[N_RULES];
    int          t_roff[N_RULES];
    int          t_rlen[N_RULES];
    attr_t       t_rattr[N_RULES];
    int          t_rnext[N_RULES];
    int          t_head[N_BUCKETS];
    logic [7:0]  t_store[N_STORE];
    bit          t_pair[PAIR_SLOTS];
    fam_bind_t   t_fam[FAMILY_COUNT];
    int          t_count;
    int          t_cursor;
    bit          t_failed;
    logic [7:0]  t_tgc;

    function automatic void table_clear();
        foreach (t_head[i]) t_head[i] = -1;
        foreach (t_pair[i]) t_pair[i] = 1'b0;
        foreach (t_fam[i]) t_fam[i] = '0;
        t_count  = 0;
        t_cursor = 0;
        t_failed = 1'b0;
        t_klen   = 0;
        t_hash   = FNV_BASIS;
    endfunction

    // Lexicographic order of a stored key against the key buffer
    function automatic int key_order(int off, int slen, int blen);
        int n;
        n = (slen < blen) ? slen : blen;
        for (int i = 0; i < n; i++)
        begin
            if (t_store[off+i] < t_kbuf[i]) return -1;
            if (t_store[off+i] > t_kbuf[i]) return 1;
        end
        if (slen < blen) return -1;
        return (slen > blen) ? 1 : 0;
    endfunction

    function automatic status_t rule_load(int len, logic [63:0] h, req_t r,
                                          output rule_res_t res);
        int pair;
        int b;
        res = '{st: ST_OK, idx: '0, a: '0};
        if (r.mem > MEMBER_MAX || len > N_KEYB || t_tgc > TGC_LIMIT ||
            t_count >= N_RULES || len > N_STORE - t_cursor ||
            (r.act == 1'b0 && r.tgt >= {8'd0, t_tgc}) ||
            (r.act == 1'b1 && r.tgt != NO_TARGET))
            return ST_INVALID;
        pair = int'(r.fam) * MEMBER_SLOTS + int'(r.mem);
        if (t_pair[pair]) return ST_DUP;
        t_pair[pair] = 1'b1;
        if (!t_fam[r.fam].bound)
            t_fam[r.fam] = '{bound: 1'b1, action: r.act, target: r.tgt};
        else if (t_fam[r.fam].action != r.act || t_fam[r.fam].target != r.tgt)
            return ST_INVALID;
        if (t_count != 0)
            if (key_order(t_roff[t_count-1], t_rlen[t_count-1], len) >= 0)
                return ST_DUP;
        for (int i = 0; i < len; i++) t_store[t_cursor+i] = t_kbuf[i];
        t_rhash[t_count] = h;
        t_roff[t_count]  = t_cursor;
        t_rlen[t_count]  = len;
        t_rattr[t_count] = '{action: r.act, target: r.tgt, family: r.fam, member: r.mem};
        b = int'(h[10:0]);
        t_rnext[t_count] = t_head[b];
        t_head[b] = t_count;
        res.idx = t_count[9:0];
        res.a   = t_rattr[t_count];
        t_count++;
        t_cursor += len;
        return ST_OK;
    endfunction

    function automatic status_t rule_lookup(int len, logic [63:0] h, output rule_res_t res);
        int idx;
        int steps;
        res = '{st: ST_OK, idx: '0, a: '0};
        if (len > N_KEYB) return ST_MISS;
        idx = t_head[int'(h[10:0])];
        steps = 0;
        while (idx != -1 && steps < t_count)
        begin
            if (idx >= t_count) break;
            if (t_rhash[idx] == h && t_rlen[idx] == len &&
                key_order(t_roff[idx], len, len) == 0)
            begin
                res.idx = idx[9:0];
                res.a   = t_rattr[idx];
                return ST_OK;
            end
            idx = t_rnext[idx];
            steps++;
        end
        return ST_MISS;
    endfunction

    // Advance the predictor by one accepted request; queue any result
    function automatic void table_step(req_t r);
        int          len;
        logic [63:0] h;
        rule_res_t   res;
        status_t     st;
        if (r.kind == KIND_CLEAR)
        begin
            table_clear();
            return;
        end
        if (r.kind == KIND_NONE) return;
        if (t_klen < N_KEYB) t_kbuf[t_klen] = r.b;
        if (t_klen <= N_KEYB) t_klen++;
        t_hash = (t_hash ^ {56'd0, r.b}) * PRIME;
        if (!r.last) return;
        len = t_klen;
        h = t_hash;
        t_klen = 0;
        t_hash = FNV_BASIS;
        res = '{st: ST_OK, idx: '0, a: '0};
        if (t_failed)
            st = ST_FAILED;
        else if (r.kind == KIND_LOOKUP)
            st = rule_lookup(len, h, res);
        else
        begin
            st = rule_load(len, h, r, res);
            if (st != ST_OK) t_failed = 1'b1;
        end
        if (st != ST_OK) res = '{st: st, idx: '0, a: '0};
        expected_rules.push_back(res);
    endfunction

    // ---------------- driver ----------------
    always @(posedge clk)
    begin
        if (cfg_we) t_tgc = cfg_wdata;
        if (start && !busy) table_step(cur);
        if (rst_n && (!start || !busy))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else if (pending_reqs.size() > 0 && !no_idle && $urandom_range(0, 15) == 0)
            begin
                gap_left = $urandom_range(0, 10);
                start <= 1'b0;
            end
            else if (pending_reqs.size() > 0)
            begin
                cur = pending_reqs.pop_front();
                start        <= 1'b1;
                kind         <= cur.kind;
                key_byte     <= cur.b;
                key_last     <= cur.last;
                action       <= cur.act;
                target_group <= cur.tgt;
                family       <= cur.fam;
                member       <= cur.mem;
            end
            else
                start <= 1'b0;
        end
    end

    // ---------------- result checker ----------------
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        if (rst_n && done)
        begin
            if (expected_rules.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("unexpected result: status %0d", status);
            end
            else
            begin
                rule_res_t e;
                e = expected_rules.pop_front();
                if (status !== e.st || rule_index !== e.idx ||
                    found_action !== e.a.action || found_target !== e.a.target ||
                    found_family !== e.a.family || found_member !== e.a.member)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp st %0d idx %0d a %0d t %h f %0d m %0d / %s",
                                 e.st, e.idx, e.a.action, e.a.target, e.a.family,
                                 e.a.member, $sformatf("got st %0d idx %0d a %0d t %h f %0d m %0d",
                                 status, rule_index, found_action, found_target,
                                 found_family, found_member));
                end
            end
        end
    end

    // ---------------- stimulus ----------------
    logic [7:0]  g_key[0:299];
    int          g_len;
    logic        ph_act[FAMILY_COUNT];
    logic [15:0] ph_tgt[FAMILY_COUNT];
    bit          ph_used[PAIR_SLOTS];
    int          lk_cnt[$];
    logic [23:0] lk_sfx[$];
    int          lk_slen[$];
    int          rand_reqs;

    task automatic push_req(kind_t k, logic [7:0] b, logic last, logic act,
                            logic [15:0] tgt, logic [6:0] fam, logic [5:0] mem);
        pending_reqs.push_back('{kind: k, b: b, last: last, act: act, tgt: tgt,
                                 fam: fam, mem: mem});
        if (k != KIND_NONE) rand_reqs++;
    endtask

    // Send g_key; bytes before the last carry random rule fields
    task automatic send_key(kind_t k, bit mixed, logic act, logic [15:0] tgt,
                            logic [6:0] fam, logic [5:0] mem);
        kind_t bk;
        for (int i = 0; i < g_len - 1; i++)
        begin
            bk = mixed ? kind_t'($urandom_range(0, 1)) : k;
            push_req(bk, g_key[i], 1'b0, 1'($urandom), 16'($urandom), 7'($urandom),
                     6'($urandom));
        end
        push_req(k, g_key[g_len-1], 1'b1, act, tgt, fam, mem);
    endtask

    // Key: big-endian counter, then suffix (first three bytes from sfx)
    task automatic make_key(int cnt, int cbytes, int slen, logic [23:0] sfx);
        g_len = cbytes + slen;
        for (int i = 0; i < cbytes; i++) g_key[i] = 8'(cnt >> (8 * (cbytes - 1 - i)));
        for (int j = 0; j < slen; j++)
            g_key[cbytes+j] = (j < 3) ? sfx[8*j +: 8] : 8'($urandom);
    endtask

    task automatic fill_key(int len, logic [7:0] v);
        g_len = len;
        for (int i = 0; i < len; i++) g_key[i] = v;
    endtask

    task automatic clear_req();
        push_req(KIND_CLEAR, 8'($urandom), 1'($urandom), 1'($urandom), 16'($urandom),
                 7'($urandom), 6'($urandom));
    endtask

    task automatic drain();
        @(negedge clk);
        while (pending_reqs.size() > 0 || start || busy || expected_rules.size() > 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic set_tgc(logic [7:0] v);
        drain();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Per-phase family bindings consistent with the group count
    task automatic new_phase(logic [7:0] tgc);
        foreach (ph_used[i]) ph_used[i] = 1'b0;
        for (int f = 0; f < FAMILY_COUNT; f++)
        begin
            ph_act[f] = (tgc == 0 || tgc > TGC_LIMIT) ? 1'b1 : 1'($urandom);
            ph_tgt[f] = ph_act[f] ? NO_TARGET : 16'($urandom_range(0, tgc - 1));
        end
        lk_cnt.delete();
        lk_sfx.delete();
        lk_slen.delete();
    endtask

    task automatic load_good(kind_t k);
        logic [6:0] f;
        logic [5:0] m;
        do
        begin
            f = 7'($urandom);
            m = 6'($urandom_range(0, 32));
        end
        while (ph_used[int'(f) * MEMBER_SLOTS + int'(m)]);
        ph_used[int'(f) * MEMBER_SLOTS + int'(m)] = 1'b1;
        send_key(k, 1'b0, ph_act[f], ph_tgt[f], f, m);
    endtask

    task automatic lookup_some();
        int p;
        if (lk_cnt.size() > 0 && $urandom_range(0, 2) != 0)
        begin
            p = $urandom_range(0, lk_cnt.size() - 1);
            make_key(lk_cnt[p], 3, lk_slen[p], lk_sfx[p]);
        end
        else
            make_key($urandom_range(0, 24'hffffff), 3, $urandom_range(0, 3), 24'($urandom));
        send_key(KIND_LOOKUP, $urandom_range(0, 7) == 0, 1'($urandom), 16'($urandom),
                 7'($urandom), 6'($urandom));
    endtask

    initial
    begin
        logic [7:0]  tgc;
        logic [23:0] sfx;
        int          cnt;
        int          n;
        int          sl;
        int          p;
        rst_n = 1'b0;
        clk = 1'b0;
        start = 1'b0;
        kind = KIND_NONE;
        key_byte = '0;
        key_last = 1'b0;
        action = 1'b0;
        target_group = '0;
        family = '0;
        member = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        gap_left = 0;
        no_idle = 1'b0;
        errors = 0;
        cycles = 0;
        rand_reqs = 0;
        t_tgc = '0;
        table_clear();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: zero group count rejects proxy, failed table, ignored kind
        fill_key(1, 8'h00);
        send_key(KIND_LOAD, 1'b0, 1'b0, 16'd0, 7'd1, 6'd0);
        send_key(KIND_LOOKUP, 1'b0, 1'b0, 16'd0, 7'd0, 6'd0);
        push_req(KIND_NONE, 8'hff, 1'b1, 1'b1, 16'hffff, 7'h7f, 6'h3f);
        clear_req();
        // Extremes of a good load, hits and a miss, repeated pair
        set_tgc(8'd128);
        fill_key(1, 8'h00);
        send_key(KIND_LOAD, 1'b0, 1'b1, NO_TARGET, 7'd127, 6'd32);
        fill_key(2, 8'hff);
        send_key(KIND_LOAD, 1'b0, 1'b0, 16'd127, 7'd0, 6'd0);
        send_key(KIND_LOOKUP, 1'b0, 1'b0, 16'd0, 7'd0, 6'd0);
        fill_key(1, 8'h00);
        send_key(KIND_LOOKUP, 1'b0, 1'b0, 16'd0, 7'd0, 6'd0);
        fill_key(1, 8'h01);
        send_key(KIND_LOOKUP, 1'b0, 1'b0, 16'd0, 7'd0, 6'd0);
        fill_key(3, 8'hff);
        send_key(KIND_LOAD, 1'b0, 1'b0, 16'd127, 7'd0, 6'd0);
        clear_req();
        // Key not above previous
        fill_key(1, 8'h10);
        send_key(KIND_LOAD, 1'b0, 1'b0, 16'd3, 7'd5, 6'd1);
        send_key(KIND_LOAD, 1'b0, 1'b0, 16'd3, 7'd6, 6'd1);
        clear_req();
        // Family target mismatch
        send_key(KIND_LOAD, 1'b0, 1'b0, 16'd3, 7'd5, 6'd1);
        fill_key(1, 8'h20);
        send_key(KIND_LOAD, 1'b0, 1'b0, 16'd4, 7'd5, 6'd2);
        clear_req();
        // Bad member, block with a target, proxy target at the count
        send_key(KIND_LOAD, 1'b0, 1'b0, 16'd3, 7'd5, 6'd63);
        clear_req();
        send_key(KIND_LOAD, 1'b0, 1'b1, 16'd0, 7'd5, 6'd1);
        clear_req();
        send_key(KIND_LOAD, 1'b0, 1'b0, 16'd128, 7'd5, 6'd1);
        clear_req();
        // Oversize keys and a full-length key
        fill_key(300, 8'h5a);
        send_key(KIND_LOOKUP, 1'b0, 1'b0, 16'd0, 7'd0, 6'd0);
        fill_key(257, 8'h5a);
        send_key(KIND_LOAD, 1'b0, 1'b0, 16'd1, 7'd9, 6'd9);
        clear_req();
        fill_key(256, 8'ha5);
        send_key(KIND_LOOKUP, 1'b0, 1'b0, 16'd0, 7'd0, 6'd0);
        send_key(KIND_LOAD, 1'b0, 1'b0, 16'd1, 7'd9, 6'd9);
        send_key(KIND_LOOKUP, 1'b0, 1'b0, 16'd0, 7'd0, 6'd0);
        // Group count above the limit rejects everything
        set_tgc(8'd255);
        clear_req();
        fill_key(1, 8'h40);
        send_key(KIND_LOAD, 1'b0, 1'b1, NO_TARGET, 7'd2, 6'd2);
        clear_req();

        // Random phases of well-formed loads with lookups and noise
        rand_reqs = 0;
        while (rand_reqs < 1350)
        begin
            case ($urandom_range(0, 9))
                0: tgc = 8'd0;
                1: tgc = 8'd128;
                2: tgc = 8'($urandom_range(129, 255));
                default: tgc = 8'($urandom_range(1, 127));
            endcase
            set_tgc(tgc);
            new_phase(tgc);
            clear_req();
            n = $urandom_range(5, 40);
            cnt = $urandom_range(0, 1000);
            for (int i = 0; i < n; i++)
            begin
                cnt += $urandom_range(1, 3000);
                sl = $urandom_range(0, 3);
                sfx = 24'($urandom);
                make_key(cnt, 3, sl, sfx);
                load_good(KIND_LOAD);
                lk_cnt.push_back(cnt);
                lk_sfx.push_back(sfx);
                lk_slen.push_back(sl);
                repeat ($urandom_range(0, 2)) lookup_some();
                if ($urandom_range(0, 9) == 0)
                    push_req(KIND_NONE, 8'($urandom), 1'($urandom), 1'($urandom),
                             16'($urandom), 7'($urandom), 6'($urandom));
            end
            // Sometimes break the table: reused key, then lookups see the failure
            if ($urandom_range(0, 3) == 0)
            begin
                p = $urandom_range(0, lk_cnt.size() - 1);
                make_key(lk_cnt[p], 3, lk_slen[p], lk_sfx[p]);
                load_good(KIND_LOAD);
                lookup_some();
                lookup_some();
            end
        end

        // Final part without idling: rule count and key store run full
        no_idle = 1'b1;
        set_tgc(8'd128);
        new_phase(8'd128);
        clear_req();
        for (int i = 0; i <= N_RULES; i++)
        begin
            make_key(i * 50 + $urandom_range(0, 49), 2, 0, 24'd0);
            load_good(KIND_LOAD);
        end
        drain();
        new_phase(8'd128);
        clear_req();
        for (int i = 0; i < 256; i++)
        begin
            make_key(i, 1, 255, 24'($urandom));
            load_good(KIND_LOAD);
            if (i % 64 == 0) send_key(KIND_LOOKUP, 1'b0, 1'b0, 16'd0, 7'd0, 6'd0);
        end
        fill_key(1, 8'hff);
        load_good(KIND_LOAD);
        clear_req();

        drain();
        repeat (20) @(posedge clk);
        if (errors == 0 && expected_rules.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
